/* rtl/script_tokenizer_macros.svh */
// ---------------------------------------------------------------------------
// script_tokenizer_macros: assertion macros
// Assertion forms used by the bundle queue.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TOKENIZER_MACROS_SVH
`define SCRIPT_TOKENIZER_MACROS_SVH

// Implication checked at every rising edge outside of reset.
`define STK_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside of reset.
`define STK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/stk_pkg.sv */
// ---------------------------------------------------------------------------
// stk_pkg: tokenizer package
// Types, character codes and token codes shared by the tokenizer modules.
// ---------------------------------------------------------------------------
package stk_pkg;

   localparam int TOKEN_CAPACITY = 1024;
   localparam int KEPT_W         = $clog2(TOKEN_CAPACITY);
   localparam int LINE_W         = 24;
   localparam int SLOTS          = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEPT_W-1:0] KEPT_LIMIT = KEPT_W'(TOKEN_CAPACITY - 1);
   localparam logic [LINE_W-1:0] LINE_MAX   = {LINE_W{1'b1}};

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_LOW_R = 8'h72;
   localparam logic [7:0] CH_LOW_N = 8'h6e;

   localparam logic [2:0] TT_EOF     = 3'd0;
   localparam logic [2:0] TT_NEWLINE = 3'd1;
   localparam logic [2:0] TT_NAME    = 3'd2;
   localparam logic [2:0] TT_STRING  = 3'd3;
   localparam logic [2:0] TT_ERROR   = 3'd4;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_EOI  = 1'b1;

   typedef enum logic [7:0] {
      MODE_IDLE      = 8'b0000_0001,
      MODE_SLASH     = 8'b0000_0010,
      MODE_LINECMT   = 8'b0000_0100,
      MODE_BLOCKCMT  = 8'b0000_1000,
      MODE_NAME      = 8'b0001_0000,
      MODE_QUOTED    = 8'b0010_0000,
      MODE_ESC_NAME  = 8'b0100_0000,
      MODE_ESC_QUOTE = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        ch;
      logic [2:0]        ttype;
      logic [LINE_W-1:0] line;
      logic              last;
   } result_type;

   typedef struct packed {
      result_type [SLOTS-1:0] slot;
      logic [1:0]             count;
   } bundle_type;

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_LOW_T: r = CH_TAB;
         CH_LOW_R: r = CH_CR;
         CH_LOW_N: r = CH_LF;
         default:  r = c;
      endcase
      return r;
   endfunction

endpackage

/* rtl/stk_if.sv */
// ---------------------------------------------------------------------------
// stk_req_if / stk_rsp_if: tokenizer channels
// Valid/ready channels for input words and result words.
// ---------------------------------------------------------------------------
interface stk_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] char_in;
   logic       skip_newlines;
   modport source (output valid, func, char_in, skip_newlines, input ready);
   modport sink (input valid, func, char_in, skip_newlines, output ready);
endinterface

interface stk_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [7:0]                char_out;
   logic [2:0]                token_type;
   logic [stk_pkg::LINE_W-1:0] line_number;
   logic                      last;
   modport source (output valid, kind, char_out, token_type, line_number, last,
                   input ready);
   modport sink (input valid, kind, char_out, token_type, line_number, last,
                 output ready);
endinterface

/* rtl/stk_queue.sv */
// ---------------------------------------------------------------------------
// stk_queue: bundle queue
// Short queue of result bundles between the scanner and the emitter.
// ---------------------------------------------------------------------------
`include "script_tokenizer_macros.svh"

module stk_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stk_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output stk_pkg::bundle_type head_data
);

   stk_pkg::bundle_type             mem_ff [stk_pkg::QUEUE_DEPTH];
   logic [stk_pkg::QPTR_W-1:0]      wr_ff, wr_in;
   logic [stk_pkg::QPTR_W-1:0]      rd_ff, rd_in;
   logic [stk_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   assign full       = (cnt_ff == stk_pkg::QCNT_W'(stk_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `STK_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full || pop, "queue overflow")
   `STK_ASSERT_IMPL(a_no_underflow, clock, reset, pop, head_valid, "queue underflow")
   `STK_ASSERT_IMPL(a_nonempty_bundle, clock, reset, push, push_data.count != 2'd0, "empty bundle")
   `STK_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "count slip")

endmodule

/* rtl/stk_front.sv */
// ---------------------------------------------------------------------------
// stk_front: scanner
// Classifies each input word, updates the scan state and forms its results.
// ---------------------------------------------------------------------------
module stk_front (
   input  logic                clock,
   input  logic                reset,
   stk_req_if.sink             req_ch,
   input  logic                queue_full,
   output logic                push,
   output stk_pkg::bundle_type push_data
);

   stk_pkg::mode_type                mode_ff, mode_in;
   logic                             acr_ff, acr_in;
   logic                             star_ff, star_in;
   logic [stk_pkg::KEPT_W-1:0]       kept_ff, kept_in;
   logic [stk_pkg::LINE_W-1:0]       line_ff, line_in;
   stk_pkg::result_type [stk_pkg::SLOTS-1:0] res_v;
   logic [1:0]                       n_v;
   logic                             do_name, do_between;
   logic [7:0]                       c;
   logic                             skip;
   logic                             accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.char_in;
   assign skip         = req_ch.skip_newlines;

   always_comb begin
      mode_in    = mode_ff;
      acr_in     = acr_ff;
      star_in    = star_ff;
      kept_in    = kept_ff;
      line_in    = line_ff;
      res_v      = '0;
      n_v        = 2'd0;
      do_name    = 1'b0;
      do_between = 1'b0;

      if (req_ch.func == stk_pkg::FUNC_EOI) begin
         case (mode_ff)
            stk_pkg::MODE_SLASH: begin
               res_v[n_v] = '{stk_pkg::KIND_CHAR, stk_pkg::CH_SLASH, stk_pkg::TT_EOF,
                              line_ff, 1'b0};
               n_v = n_v + 1'b1;
               res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_ERROR, line_ff, 1'b0};
               n_v = n_v + 1'b1;
            end
            stk_pkg::MODE_BLOCKCMT, stk_pkg::MODE_NAME, stk_pkg::MODE_QUOTED,
            stk_pkg::MODE_ESC_NAME, stk_pkg::MODE_ESC_QUOTE: begin
               res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_ERROR, line_ff, 1'b0};
               n_v = n_v + 1'b1;
            end
            default: begin
            end
         endcase
         res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_EOF, line_ff, 1'b0};
         n_v = n_v + 1'b1;
         mode_in = stk_pkg::MODE_IDLE;
         acr_in  = 1'b0;
         star_in = 1'b0;
         kept_in = '0;
         line_in = stk_pkg::LINE_W'(1);
      end else begin
         case (mode_ff)
            stk_pkg::MODE_SLASH: begin
               if (c == stk_pkg::CH_SLASH) begin
                  mode_in = stk_pkg::MODE_LINECMT;
               end else if (c == stk_pkg::CH_STAR) begin
                  mode_in = stk_pkg::MODE_BLOCKCMT;
                  star_in = 1'b1;
               end else begin
                  mode_in = stk_pkg::MODE_NAME;
                  kept_in = stk_pkg::KEPT_W'(1);
                  res_v[n_v] = '{stk_pkg::KIND_CHAR, stk_pkg::CH_SLASH, stk_pkg::TT_EOF,
                                 line_in, 1'b0};
                  n_v = n_v + 1'b1;
                  do_name = 1'b1;
               end
            end
            stk_pkg::MODE_LINECMT: begin
               if (c == stk_pkg::CH_CR || c == stk_pkg::CH_LF) begin
                  mode_in    = stk_pkg::MODE_IDLE;
                  do_between = 1'b1;
               end
            end
            stk_pkg::MODE_BLOCKCMT: begin
               if (star_ff && c == stk_pkg::CH_SLASH) begin
                  mode_in = stk_pkg::MODE_IDLE;
                  star_in = 1'b0;
                  acr_in  = 1'b0;
               end else begin
                  star_in = (c == stk_pkg::CH_STAR);
                  if (c == stk_pkg::CH_LF) begin
                     if (acr_ff) begin
                        acr_in = 1'b0;
                     end else if (line_in != stk_pkg::LINE_MAX) begin
                        line_in = line_in + 1'b1;
                     end
                  end else if (c == stk_pkg::CH_CR) begin
                     if (line_in != stk_pkg::LINE_MAX) begin
                        line_in = line_in + 1'b1;
                     end
                     acr_in = 1'b1;
                  end else begin
                     acr_in = 1'b0;
                  end
               end
            end
            stk_pkg::MODE_NAME: begin
               do_name = 1'b1;
            end
            stk_pkg::MODE_QUOTED: begin
               if (c == stk_pkg::CH_QUOTE) begin
                  res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_STRING, line_in, 1'b0};
                  n_v = n_v + 1'b1;
                  mode_in = stk_pkg::MODE_IDLE;
               end else if (c == stk_pkg::CH_CR || c == stk_pkg::CH_LF) begin
                  res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_ERROR, line_in, 1'b0};
                  n_v = n_v + 1'b1;
                  mode_in    = stk_pkg::MODE_IDLE;
                  do_between = 1'b1;
               end else if (c == stk_pkg::CH_BSL) begin
                  mode_in = stk_pkg::MODE_ESC_QUOTE;
               end else if (kept_in < stk_pkg::KEPT_LIMIT) begin
                  kept_in = kept_in + 1'b1;
                  res_v[n_v] = '{stk_pkg::KIND_CHAR, c, stk_pkg::TT_EOF, line_in, 1'b0};
                  n_v = n_v + 1'b1;
               end
            end
            stk_pkg::MODE_ESC_NAME, stk_pkg::MODE_ESC_QUOTE: begin
               mode_in = (mode_ff == stk_pkg::MODE_ESC_NAME) ? stk_pkg::MODE_NAME
                                                             : stk_pkg::MODE_QUOTED;
               if (kept_in < stk_pkg::KEPT_LIMIT) begin
                  kept_in = kept_in + 1'b1;
                  res_v[n_v] = '{stk_pkg::KIND_CHAR, stk_pkg::decode_escape(c),
                                 stk_pkg::TT_EOF, line_in, 1'b0};
                  n_v = n_v + 1'b1;
               end
            end
            default: begin
               mode_in    = stk_pkg::MODE_IDLE;
               do_between = 1'b1;
            end
         endcase

         // Name byte: a blank closes the name and is then scanned again.
         if (do_name) begin
            if (c <= stk_pkg::CH_SPACE) begin
               res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_NAME, line_in, 1'b0};
               n_v = n_v + 1'b1;
               mode_in    = stk_pkg::MODE_IDLE;
               do_between = 1'b1;
            end else if (c == stk_pkg::CH_BSL) begin
               mode_in = stk_pkg::MODE_ESC_NAME;
            end else if (kept_in < stk_pkg::KEPT_LIMIT) begin
               kept_in = kept_in + 1'b1;
               res_v[n_v] = '{stk_pkg::KIND_CHAR, c, stk_pkg::TT_EOF, line_in, 1'b0};
               n_v = n_v + 1'b1;
            end
         end

         // Between tokens: line breaks, blanks and the start of a token.
         if (do_between) begin
            if (c == stk_pkg::CH_LF) begin
               if (acr_in) begin
                  acr_in = 1'b0;
               end else begin
                  if (line_in != stk_pkg::LINE_MAX) begin
                     line_in = line_in + 1'b1;
                  end
                  if (!skip) begin
                     res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_NEWLINE,
                                    line_in, 1'b0};
                     n_v = n_v + 1'b1;
                  end
               end
            end else if (c == stk_pkg::CH_CR) begin
               if (line_in != stk_pkg::LINE_MAX) begin
                  line_in = line_in + 1'b1;
               end
               if (!skip) begin
                  res_v[n_v] = '{stk_pkg::KIND_END, 8'd0, stk_pkg::TT_NEWLINE, line_in, 1'b0};
                  n_v = n_v + 1'b1;
               end
               acr_in = 1'b1;
            end else begin
               acr_in = 1'b0;
               if (c <= stk_pkg::CH_SPACE) begin
                  mode_in = stk_pkg::MODE_IDLE;
               end else if (c == stk_pkg::CH_SLASH) begin
                  mode_in = stk_pkg::MODE_SLASH;
               end else if (c == stk_pkg::CH_QUOTE) begin
                  mode_in = stk_pkg::MODE_QUOTED;
                  kept_in = '0;
               end else begin
                  mode_in = stk_pkg::MODE_NAME;
                  kept_in = stk_pkg::KEPT_W'(1);
                  res_v[n_v] = '{stk_pkg::KIND_CHAR, c, stk_pkg::TT_EOF, line_in, 1'b0};
                  n_v = n_v + 1'b1;
               end
            end
         end
      end

      if (n_v != 2'd0) begin
         res_v[n_v - 1'b1].last = 1'b1;
      end
   end

   assign push            = accept && (n_v != 2'd0);
   assign push_data.slot  = res_v;
   assign push_data.count = n_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stk_pkg::MODE_IDLE;
         acr_ff  <= 1'b0;
         star_ff <= 1'b0;
         kept_ff <= '0;
         line_ff <= stk_pkg::LINE_W'(1);
      end else if (accept) begin
         mode_ff <= mode_in;
         acr_ff  <= acr_in;
         star_ff <= star_in;
         kept_ff <= kept_in;
         line_ff <= line_in;
      end
   end

endmodule

/* rtl/stk_back.sv */
// ---------------------------------------------------------------------------
// stk_back: result emitter
// Sends the results of each queued bundle one word per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module stk_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  stk_pkg::bundle_type head_data,
   output logic                pop,
   stk_rsp_if.source           rsp_ch
);

   logic [1:0]          sel_ff, sel_in;
   logic                valid_ff;
   stk_pkg::result_type data_ff;
   logic                load;
   logic                end_of_bundle;

   assign load          = head_valid && (!valid_ff || rsp_ch.ready);
   assign end_of_bundle = (sel_ff == head_data.count - 1'b1);
   assign pop           = load && end_of_bundle;
   assign sel_in        = load ? (end_of_bundle ? 2'd0 : sel_ff + 1'b1) : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head_data.slot[sel_ff];
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.kind        = data_ff.kind;
   assign rsp_ch.char_out    = data_ff.ch;
   assign rsp_ch.token_type  = data_ff.ttype;
   assign rsp_ch.line_number = data_ff.line;
   assign rsp_ch.last        = data_ff.last;

endmodule

/* rtl/script_tokenizer.sv */
// ---------------------------------------------------------------------------
// script_tokenizer: streaming script tokenizer
// Turns a stream of text bytes into name, string, newline and end tokens.
// ---------------------------------------------------------------------------
// The first result of a word passes through the bundle queue and then the output register.
// Throughput: one word per cycle while each word yields at most one result and the receiver is ready;
// a word yielding several results holds the emitter until all of them are sent.
// The scanner keeps taking words until its four-bundle queue fills up.
// Reset is synchronous: scanning restarts between tokens on line one and
// the queue and the output register are emptied.
module script_tokenizer (
   input  logic      clock,
   input  logic      reset,
   stk_req_if.sink   req_ch,
   stk_rsp_if.source rsp_ch
);

   // The scanner writes one bundle per word that yields any result.
   logic                push;
   stk_pkg::bundle_type push_data;
   logic                full;

   // The emitter pops a bundle once its final word is loaded for output.
   logic                pop;
   logic                head_valid;
   stk_pkg::bundle_type head_data;

   stk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   stk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   stk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
